// ===== sv/tpcm_pkg.sv =====
`timescale 1ns / 1ps

package tpcm_pkg;

  // Default geometry
  localparam int unsigned RING_SAMPLES_DEF   = 4096;
  localparam int unsigned FRAME_SAMPLES_DEF  = 256;
  localparam int unsigned NUM_POOLS_DEF      = 2;
  localparam int unsigned MAX_READ_DEF       = 64;
  localparam int unsigned PREFILL_FACTOR_DEF = 4;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TS_IN_W  = 31;
  localparam int unsigned TS_OUT_W = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DELTA_W  = 16;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 64;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd1000;

  // Timestamp scale: floor(x / 1000) as (x * floor(2^32 / 1000)) >> 32 plus one fixup
  localparam int unsigned        TS_SCALE    = 1000;
  localparam int unsigned        RECIP_SHIFT = 32;
  localparam int unsigned        RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP_MULT  = 23'd4294967;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TS_MUL,
    ST_TS_RECIP,
    ST_TS_FIX,
    ST_TS_SUM,
    ST_STREAM,
    ST_REFUSE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec_write;
    logic exec_read;
    logic ts_latch;
    logic stream;
    logic finish;
    logic refuse;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic pool_ok;
    logic grant;
    logic stream_done;
    logic out_free;
  } stat_t;

endpackage

// ===== sv/tpcm_ram.sv =====
`timescale 1ns / 1ps

module tpcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                           clk_i,
  input  logic                                           we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]                               wdata_i,
  input  logic                                           re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr_i,
  output logic [WIDTH-1:0]                               rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tpcm_ctrl.sv =====
`timescale 1ns / 1ps

module tpcm_ctrl import tpcm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_valid_i,
  output logic  s_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!stat_i.is_read) begin
          cmd_o.exec_write = 1'b1;
          state_d          = ST_IDLE;
        end else if (!stat_i.pool_ok) begin
          state_d = ST_REFUSE;
        end else begin
          cmd_o.exec_read = 1'b1;
          state_d         = stat_i.grant ? ST_TS_MUL : ST_REFUSE;
        end
      end
      ST_TS_MUL:   state_d = ST_TS_RECIP;
      ST_TS_RECIP: state_d = ST_TS_FIX;
      ST_TS_FIX:   state_d = ST_TS_SUM;
      ST_TS_SUM: begin
        cmd_o.ts_latch = 1'b1;
        state_d        = ST_STREAM;
      end
      ST_STREAM: begin
        cmd_o.stream = 1'b1;
        if (stat_i.stream_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        cmd_o.refuse = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/tpcm_datapath.sv =====
`timescale 1ns / 1ps

module tpcm_datapath import tpcm_pkg::*; #(
  parameter int unsigned RING_SAMPLES   = RING_SAMPLES_DEF,
  parameter int unsigned FRAME_SAMPLES  = FRAME_SAMPLES_DEF,
  parameter int unsigned NUM_POOLS      = NUM_POOLS_DEF,
  parameter int unsigned MAX_READ       = MAX_READ_DEF,
  parameter int unsigned PREFILL_FACTOR = PREFILL_FACTOR_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic                   cfg_valid_i,
  input  logic [DELTA_W-1:0]     cfg_data_i,
  input  logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [IN_TUSER_W-1:0]  s_tuser_i,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [OUT_TDATA_W-1:0] m_tdata_o,
  output logic [OUT_TUSER_W-1:0] m_tuser_o,
  output logic                   m_tlast_o
);

  localparam int unsigned PTR_W       = $clog2(RING_SAMPLES);
  localparam int unsigned OFF_W       = $clog2(FRAME_SAMPLES);
  localparam int unsigned FRAME_SLOTS = (RING_SAMPLES + FRAME_SAMPLES - 1) / FRAME_SAMPLES;
  localparam int unsigned SLOT_W      = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int unsigned PIDX_W      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned CNT_W       = $clog2(MAX_READ + 1);
  localparam int unsigned NEED_W      = CNT_W + $clog2(PREFILL_FACTOR + 1);
  localparam int unsigned CMP_W       = ((PTR_W > NEED_W) ? PTR_W : NEED_W) + 1;
  localparam int unsigned PROD_W      = OFF_W + DELTA_W;
  localparam int unsigned MUL_W       = PROD_W + RECIP_W;
  localparam int unsigned Q_W         = MUL_W - RECIP_SHIFT;
  localparam int unsigned SMP_AW      = PIDX_W + PTR_W;
  localparam int unsigned FTS_AW      = PIDX_W + SLOT_W;
  localparam int unsigned SMP_DEPTH   = 2 ** SMP_AW;
  localparam int unsigned FTS_DEPTH   = 2 ** FTS_AW;

  // Ring position with its frame slot and offset kept alongside
  typedef struct packed {
    logic [PTR_W-1:0]  ptr;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  off;
  } pos_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_t r;
    r = p;
    if (p.ptr == PTR_W'(RING_SAMPLES - 1)) begin
      r = '0;
    end else begin
      r.ptr = p.ptr + 1'b1;
      if (p.off == OFF_W'(FRAME_SAMPLES - 1)) begin
        r.off  = '0;
        r.slot = p.slot + 1'b1;
      end else begin
        r.off = p.off + 1'b1;
      end
    end
    return r;
  endfunction

  // Configuration
  logic [DELTA_W-1:0] delta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= DELTA_RESET;
    end else if (cfg_valid_i) begin
      delta_q <= cfg_data_i;
    end
  end

  // Captured input beat
  action_e                    act_q;
  logic                       pool_q;
  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic                       mono_q;
  logic                       fstart_q;
  logic [TS_IN_W-1:0]         tsin_q;
  logic [COUNT_W-1:0]         cnt_q;
  logic                       adv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q    <= action_e'(s_tuser_i[0]);
      pool_q   <= s_tuser_i[1];
      left_q   <= s_tdata_i[15:0];
      right_q  <= s_tdata_i[31:16];
      mono_q   <= s_tdata_i[32];
      fstart_q <= s_tdata_i[33];
      tsin_q   <= s_tdata_i[64:34];
      cnt_q    <= s_tdata_i[71:65];
      adv_q    <= s_tdata_i[72];
    end
  end

  // Per-pool pointers and flags
  pos_t wpos_q    [NUM_POOLS];
  pos_t rpos_q    [NUM_POOLS];
  logic started_q [NUM_POOLS];
  logic prefill_q [NUM_POOLS];

  logic [PIDX_W-1:0]  pidx;
  logic               pool_ok;
  pos_t               wpos;
  pos_t               start;
  logic [PTR_W-1:0]   avail;
  logic [COUNT_W-1:0] n_full;
  logic [CNT_W-1:0]   n_sel;
  logic [NEED_W-1:0]  need;
  logic               grant;

  // Evaluate a read request against the selected ring
  always_comb begin
    pidx    = PIDX_W'(pool_q);
    pool_ok = (32'(pool_q) < 32'(NUM_POOLS));
    wpos    = wpos_q[pidx];
    start   = started_q[pidx] ? rpos_q[pidx] : wpos;
    if (wpos.ptr >= start.ptr) begin
      avail = wpos.ptr - start.ptr;
    end else begin
      avail = PTR_W'((PTR_W + 1)'(RING_SAMPLES) - {1'b0, start.ptr} + {1'b0, wpos.ptr});
    end
    if (cnt_q == '0) begin
      n_full = COUNT_W'(1);
    end else if (cnt_q > COUNT_W'(MAX_READ)) begin
      n_full = COUNT_W'(MAX_READ);
    end else begin
      n_full = cnt_q;
    end
    n_sel = CNT_W'(n_full);
    need  = prefill_q[pidx] ? NEED_W'(n_sel * PREFILL_FACTOR) : NEED_W'(n_sel);
    grant = CMP_W'(avail) >= CMP_W'(need);
  end

  // Read cursor and stream control
  pos_t             cur_q;
  logic [CNT_W-1:0] remain_q;
  logic             pend_q;
  logic             out_valid_q;
  logic             out_free;
  logic             load_smp;
  logic             rd_en;

  assign out_free = !out_valid_q || m_tready_i;
  assign load_smp = cmd_i.stream && pend_q && out_free;
  assign rd_en    = cmd_i.stream && (remain_q != '0) && (!pend_q || load_smp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POOLS; i++) begin
        wpos_q[i]    <= '0;
        rpos_q[i]    <= '0;
        started_q[i] <= 1'b0;
        prefill_q[i] <= 1'b1;
      end
      remain_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      // Advance the write pointer
      if (cmd_i.exec_write && pool_ok) begin
        wpos_q[pidx] <= pos_inc(wpos);
      end
      // Start a read: pin the reader, update prefill, load the cursor
      if (cmd_i.exec_read) begin
        started_q[pidx] <= 1'b1;
        if (!started_q[pidx]) begin
          rpos_q[pidx] <= wpos;
        end
        prefill_q[pidx] <= !grant;
        remain_q        <= n_sel;
        pend_q          <= 1'b0;
      end
      if (rd_en) begin
        remain_q <= remain_q - 1'b1;
      end
      if (rd_en) begin
        pend_q <= 1'b1;
      end else if (load_smp) begin
        pend_q <= 1'b0;
      end
      // Move the reader past the samples read
      if (cmd_i.finish && adv_q) begin
        rpos_q[pidx] <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_read) begin
      cur_q <= start;
    end else if (rd_en) begin
      cur_q <= pos_inc(cur_q);
    end
  end

  // Sample store: right channel in the upper half
  logic [2*SAMPLE_W-1:0] smp_rdata;

  tpcm_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (SMP_DEPTH)
  ) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec_write && pool_ok),
    .waddr_i ({pidx, wpos.ptr}),
    .wdata_i ({(mono_q ? left_q : right_q), left_q}),
    .re_i    (rd_en),
    .raddr_i ({pidx, cur_q.ptr}),
    .rdata_o (smp_rdata)
  );

  // Frame timestamp store; a slot never written reads as zero
  logic [TS_IN_W-1:0]   fts_rdata;
  logic [FTS_DEPTH-1:0] fts_valid_q;
  logic                 fts_hit_q;
  logic                 fts_we;

  assign fts_we = cmd_i.exec_write && pool_ok && fstart_q;

  tpcm_ram #(
    .WIDTH (TS_IN_W),
    .DEPTH (FTS_DEPTH)
  ) u_fts_ram (
    .clk_i   (clk_i),
    .we_i    (fts_we),
    .waddr_i ({pidx, wpos.slot}),
    .wdata_i (tsin_q),
    .re_i    (cmd_i.exec_read),
    .raddr_i ({pidx, start.slot}),
    .rdata_o (fts_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fts_valid_q <= '0;
      fts_hit_q   <= 1'b0;
    end else begin
      if (fts_we) begin
        fts_valid_q[{pidx, wpos.slot}] <= 1'b1;
      end
      if (cmd_i.exec_read) begin
        fts_hit_q <= fts_valid_q[{pidx, start.slot}];
      end
    end
  end

  // Timestamp: offset * delta, then divide by 1000 through the reciprocal
  logic [PROD_W-1:0]   prod_q;
  logic [MUL_W-1:0]    mul_q;
  logic [Q_W-1:0]      q_q;
  logic [Q_W-1:0]      q0;
  logic [PROD_W-1:0]   q0_scaled;
  logic [PROD_W-1:0]   rem;
  logic [TS_OUT_W-1:0] fts;
  logic [TS_OUT_W-1:0] ts_q;

  always_comb begin
    q0        = mul_q[MUL_W-1:RECIP_SHIFT];
    q0_scaled = PROD_W'({10'b0, q0} * (Q_W + 10)'(TS_SCALE));
    rem       = prod_q - q0_scaled;
    fts       = fts_hit_q ? {1'b0, fts_rdata} : '0;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{DELTA_W{1'b0}}, cur_q.off} * {{OFF_W{1'b0}}, delta_q};
    mul_q  <= MUL_W'(prod_q) * MUL_W'(RECIP_MULT);
    q_q    <= (rem >= PROD_W'(TS_SCALE)) ? q0 + 1'b1 : q0;
    if (cmd_i.ts_latch) begin
      ts_q <= fts + TS_OUT_W'(q_q);
    end
  end

  // Output register
  logic [SAMPLE_W-1:0] out_left_q;
  logic [SAMPLE_W-1:0] out_right_q;
  logic [TS_OUT_W-1:0] out_ts_q;
  logic                out_status_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_smp || (cmd_i.refuse && out_free)) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_smp) begin
      out_left_q   <= smp_rdata[SAMPLE_W-1:0];
      out_right_q  <= smp_rdata[2*SAMPLE_W-1:SAMPLE_W];
      out_ts_q     <= ts_q;
      out_status_q <= 1'b0;
      out_last_q   <= (remain_q == '0);
    end else if (cmd_i.refuse && out_free) begin
      out_left_q   <= '0;
      out_right_q  <= '0;
      out_ts_q     <= '0;
      out_status_q <= 1'b1;
      out_last_q   <= 1'b1;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_ts_q, out_right_q, out_left_q};
  assign m_tuser_o  = out_status_q;
  assign m_tlast_o  = out_last_q;

  // Status to controller
  assign stat_o.is_read     = (act_q == ACT_READ);
  assign stat_o.pool_ok     = pool_ok;
  assign stat_o.grant       = grant;
  assign stat_o.stream_done = (remain_q == '0) && !pend_q;
  assign stat_o.out_free    = out_free;

endmodule

// ===== sv/timestamped_pcm_ring_buffer.sv =====
`timescale 1ns / 1ps
// Write beat: captured when accepted, committed in the next cycle.
// Granted read of N samples: evaluate state, then timestamp multiply and divide-by-1000
// states, then one sample per cycle from the sample RAM's registered port unless stalled.
// Refused read: one status beat once the output is free. Next beat is taken once done.
// Reset: pointers zero, prefill armed, timestamp slots read as zero, delta 1000.
module timestamped_pcm_ring_buffer import tpcm_pkg::*; #(
  parameter int unsigned RING_SAMPLES   = RING_SAMPLES_DEF,
  parameter int unsigned FRAME_SAMPLES  = FRAME_SAMPLES_DEF,
  parameter int unsigned NUM_POOLS      = NUM_POOLS_DEF,
  parameter int unsigned MAX_READ       = MAX_READ_DEF,
  parameter int unsigned PREFILL_FACTOR = PREFILL_FACTOR_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration: timestamp_delta
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [DELTA_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: left_in, right_in, mono, frame_start, timestamp_in, read_count, advance, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: action, pool
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser_i,
  // Result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: left_out, right_out, timestamp_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [OUT_TUSER_W-1:0] m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  tpcm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tpcm_datapath #(
    .RING_SAMPLES   (RING_SAMPLES),
    .FRAME_SAMPLES  (FRAME_SAMPLES),
    .NUM_POOLS      (NUM_POOLS),
    .MAX_READ       (MAX_READ),
    .PREFILL_FACTOR (PREFILL_FACTOR)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

// ===== bench/timestamped_pcm_ring_buffer_test.sv =====
`timescale 1ns / 1ps

module timestamped_pcm_ring_buffer_test;
  import tpcm_pkg::*;

  localparam int unsigned RING        = RING_SAMPLES_DEF;
  localparam int unsigned FRAME       = FRAME_SAMPLES_DEF;
  localparam int unsigned POOLS       = NUM_POOLS_DEF;
  localparam int unsigned SLOTS       = RING / FRAME;
  localparam int unsigned PTR_W       = $clog2(RING);
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PRINT_CAP   = 40;
  localparam int unsigned LONG_RUN    = 48;

  // One input beat, unpacked
  typedef struct {
    action_e              action;
    logic                 pool;
    logic [SAMPLE_W-1:0]  left;
    logic [SAMPLE_W-1:0]  right;
    logic                 mono;
    logic                 fstart;
    logic [TS_IN_W-1:0]   ts;
    logic [COUNT_W-1:0]   count;
    logic                 adv;
  } pcm_item_t;

  // One result beat
  typedef struct {
    logic [SAMPLE_W-1:0]  left;
    logic [SAMPLE_W-1:0]  right;
    logic [TS_OUT_W-1:0]  ts;
    logic                 status;
    logic                 last;
  } pcm_beat_t;

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [DELTA_W-1:0]     cfg_data   = '0;
  logic                   s_tvalid   = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata    = '0;
  logic [IN_TUSER_W-1:0]  s_tuser    = '0;
  logic                   m_tvalid;
  logic                   m_tready   = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;

  timestamped_pcm_ring_buffer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the rings
  logic [SAMPLE_W-1:0] left_mem   [POOLS][RING];
  logic [SAMPLE_W-1:0] right_mem  [POOLS][RING];
  logic [TS_OUT_W-1:0] frame_ts   [POOLS][SLOTS];
  logic [PTR_W-1:0]    wr_ptr     [POOLS];
  logic [PTR_W-1:0]    rd_ptr     [POOLS];
  logic                started    [POOLS];
  logic                prefill    [POOLS];
  logic [DELTA_W-1:0]  delta_reg;

  pcm_item_t   pending_items [$];
  pcm_beat_t   expected_beats [$];
  pcm_item_t   held_item;
  bit          quiet = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned writes_seen = 0;
  int unsigned grants = 0;
  int unsigned refusals = 0;
  int unsigned beats_checked = 0;
  int unsigned delta_writes = 0;

  initial begin
    for (int p = 0; p < POOLS; p++) begin
      for (int s = 0; s < SLOTS; s++) frame_ts[p][s] = '0;
      wr_ptr[p]  = '0;
      rd_ptr[p]  = '0;
      started[p] = 1'b0;
      prefill[p] = 1'b1;
    end
    delta_reg = DELTA_RESET;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic push_refusal();
    pcm_beat_t b;
    b.left   = '0;
    b.right  = '0;
    b.ts     = '0;
    b.status = 1'b1;
    b.last   = 1'b1;
    expected_beats.push_back(b);
    refusals++;
  endtask

  // Apply one accepted beat to the shadow rings and queue the result beats it yields
  task automatic apply_ring_beat(input pcm_item_t it);
    logic [PTR_W-1:0]    w, t, avail;
    logic [8:0]          need;
    logic [6:0]          n;
    logic [63:0]         inc;
    logic [TS_OUT_W-1:0] ts;
    pcm_beat_t           b;
    if (it.action == ACT_WRITE) begin
      w = wr_ptr[it.pool];
      if (it.fstart) frame_ts[it.pool][w / FRAME] = {1'b0, it.ts};
      left_mem[it.pool][w]  = it.left;
      right_mem[it.pool][w] = it.mono ? it.left : it.right;
      wr_ptr[it.pool] = w + 1'b1;
      writes_seen++;
    end else begin
      // Saturate the count into 1..MAX_READ
      if (it.count == 0) n = 7'd1;
      else if (it.count > MAX_READ_DEF) n = 7'(MAX_READ_DEF);
      else n = it.count;
      // First use starts the reader at the writer
      if (!started[it.pool]) begin
        started[it.pool] = 1'b1;
        rd_ptr[it.pool]  = wr_ptr[it.pool];
      end
      t     = rd_ptr[it.pool];
      avail = wr_ptr[it.pool] - t;
      need  = prefill[it.pool] ? 9'(n * PREFILL_FACTOR_DEF) : 9'(n);
      if ({3'b0, avail} < 15'(need)) begin
        prefill[it.pool] = 1'b1;
        push_refusal();
      end else begin
        inc = (64'(t % FRAME) * 64'(delta_reg)) / TS_SCALE;
        ts  = frame_ts[it.pool][t / FRAME] + inc[31:0];
        for (int k = 0; k < n; k++) begin
          b.left   = left_mem[it.pool][PTR_W'(t + k)];
          b.right  = right_mem[it.pool][PTR_W'(t + k)];
          b.ts     = ts;
          b.status = 1'b0;
          b.last   = (k + 1 == n);
          expected_beats.push_back(b);
        end
        if (it.adv) rd_ptr[it.pool] = t + PTR_W'(n);
        prefill[it.pool] = 1'b0;
        grants++;
      end
    end
  endtask

  // Driver: offer queued beats, hold until taken, then idle a while
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) apply_ring_beat(held_item);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          held_item = pending_items.pop_front();
          s_tdata  <= {7'b0, held_item.adv, held_item.count, held_item.ts,
                       held_item.fstart, held_item.mono, held_item.right, held_item.left};
          s_tuser  <= {held_item.pool, held_item.action};
          s_tvalid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expected one
  always @(posedge clk_i) begin
    pcm_beat_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (expected_beats.size() == 0) begin
          flag_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
        end else begin
          want = expected_beats.pop_front();
          if (m_tdata[15:0] !== want.left)
            flag_mismatch("left_out", 32'(m_tdata[15:0]), 32'(want.left));
          if (m_tdata[31:16] !== want.right)
            flag_mismatch("right_out", 32'(m_tdata[31:16]), 32'(want.right));
          if (m_tdata[63:32] !== want.ts)
            flag_mismatch("timestamp_out", m_tdata[63:32], want.ts);
          if (m_tuser[0] !== want.status)
            flag_mismatch("status", 32'(m_tuser[0]), 32'(want.status));
          if (m_tlast !== want.last)
            flag_mismatch("last", 32'(m_tlast), 32'(want.last));
          beats_checked++;
        end
      end
      // Stall the result side at random
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 12) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("[timestamped_pcm_ring_buffer] ERROR");
      $finish;
    end
  end

  task automatic add_write(input logic pool, input logic [15:0] left,
                           input logic [15:0] right, input logic mono,
                           input logic fstart, input logic [30:0] ts);
    pcm_item_t it;
    it.action = ACT_WRITE;
    it.pool   = pool;
    it.left   = left;
    it.right  = right;
    it.mono   = mono;
    it.fstart = fstart;
    it.ts     = ts;
    it.count  = 7'($urandom);
    it.adv    = 1'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic add_read(input logic pool, input logic [6:0] count, input logic adv);
    pcm_item_t it;
    it.action = ACT_READ;
    it.pool   = pool;
    it.left   = 16'($urandom);
    it.right  = 16'($urandom);
    it.mono   = 1'($urandom);
    it.fstart = 1'($urandom);
    it.ts     = 31'($urandom);
    it.count  = count;
    it.adv    = adv;
    pending_items.push_back(it);
  endtask

  task automatic add_random_write(input logic pool, input logic fstart);
    add_write(pool, 16'($urandom), 16'($urandom), 1'($urandom), fstart, 31'($urandom));
  endtask

  // Puts of a few samples mixed with reads of mostly small sizes
  task automatic add_random_items(input int unsigned target);
    int unsigned made, burst, r;
    logic        pool;
    logic [6:0]  count;
    made = 0;
    while (made < target) begin
      pool = 1'($urandom);
      if ($urandom_range(0, 99) < 55) begin
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) begin
          add_random_write(pool, k == 0 || $urandom_range(0, 9) == 0);
          made++;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) count = 7'($urandom_range(1, 4));
        else if (r < 85) count = 7'($urandom_range(5, 16));
        else if (r < 95) count = 7'($urandom_range(17, 64));
        else count = 7'($urandom_range(0, 127));
        add_read(pool, count, $urandom_range(0, 3) != 0);
        made++;
      end
    end
  endtask

  // Steady stream of writes into one ring with a read now and then
  task automatic add_long_run();
    for (int i = 0; i < LONG_RUN; i++) begin
      add_random_write(1'b1, $urandom_range(0, 31) == 0);
      if (i % 16 == 15) add_read(1'b1, 7'($urandom_range(4, 16)), 1'b1);
    end
  endtask

  task automatic add_directed();
    // Ring 0: first use on an empty ring, then prefill, grants and saturation
    add_read(1'b0, 7'd1, 1'b1);
    add_write(1'b0, 16'h8000, 16'h7FFF, 1'b0, 1'b1, 31'h7FFF_FFFF);
    add_write(1'b0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 31'h0);
    add_write(1'b0, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 31'h5555_5555);
    add_write(1'b0, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 31'h2AAA_AAAA);
    add_read(1'b0, 7'd1, 1'b1);
    add_read(1'b0, 7'd0, 1'b0);
    add_read(1'b0, 7'd127, 1'b1);
    add_read(1'b0, 7'd1, 1'b0);
    // Ring 1: reader starts past the first samples
    add_write(1'b1, 16'h0000, 16'h1234, 1'b0, 1'b1, 31'h0);
    add_write(1'b1, 16'hFFFF, 16'h4321, 1'b1, 1'b0, 31'h0);
    add_read(1'b1, 7'd1, 1'b0);
    add_write(1'b1, 16'h0001, 16'hFFFE, 1'b0, 1'b1, 31'd123456);
    add_write(1'b1, 16'h8001, 16'h7FFE, 1'b0, 1'b0, 31'h0);
    add_write(1'b1, 16'h4000, 16'hC000, 1'b1, 1'b0, 31'h0);
    add_write(1'b1, 16'h00FF, 16'hFF00, 1'b0, 1'b0, 31'h0);
    add_read(1'b1, 7'd1, 1'b1);
    add_read(1'b1, 7'd64, 1'b1);
  endtask

  // Wait until the sender is empty and every expected beat has come, then settle
  task automatic drain_pipeline();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || s_tvalid || expected_beats.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_delta(input logic [DELTA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    delta_reg = value;
    delta_writes++;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_directed();
    drain_pipeline();

    write_delta(16'h0000);
    add_random_items(35);
    drain_pipeline();

    write_delta(16'hFFFF);
    add_random_items(35);
    drain_pipeline();

    write_delta(16'($urandom_range(1, 65534)));
    add_random_items(35);
    drain_pipeline();

    // Back-to-back stretch with no idling on either side
    write_delta(16'd999);
    quiet = 1'b1;
    add_long_run();
    drain_pipeline();
    quiet = 1'b0;

    write_delta(DELTA_RESET);
    add_random_items(35);
    drain_pipeline();
    repeat (20) @(posedge clk_i);

    if (expected_beats.size() != 0)
      flag_mismatch("missing beats", 32'(expected_beats.size()), 32'h0);

    $display("covered %0d writes, %0d granted and %0d refused reads, %0d result beats",
             writes_seen, grants, refusals, beats_checked);
    $display("over %0d delta settings incl. 0 and 65535, with one back-to-back stretch",
             delta_writes + 1);
    if (error_count == 0) begin
      $display("[timestamped_pcm_ring_buffer] OK");
    end else begin
      $display("[timestamped_pcm_ring_buffer] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpcm_pkg.sv
sv/tpcm_ram.sv
sv/tpcm_ctrl.sv
sv/tpcm_datapath.sv
sv/timestamped_pcm_ring_buffer.sv
bench/timestamped_pcm_ring_buffer_test.sv
